### hdl/pfit_pkg.sv
// ----------------------------------------------------------------------------
// pfit_pkg
// Shared types and constants for the plane fit and inlier test block.
// ----------------------------------------------------------------------------
package pfit_pkg;

	// input action codes
	localparam logic ACT_FIT  = 1'b0;
	localparam logic ACT_TEST = 1'b1;

	// fixed point formats
	localparam int FRAC_BITS  = 12;
	localparam int COEF_FRAC  = 16;
	localparam int COEF_W     = 32;
	localparam int THRESH_W   = 15;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd82;
	// 1.0 in the scale of coefficient times coordinate
	localparam longint COEF_ONE = 64'sd1 << (FRAC_BITS + COEF_FRAC);
	// extra shift applied to the numerator before division (one more for rounding)
	localparam int NUM_SHIFT  = FRAC_BITS + COEF_FRAC + 1;

	// shared multiplier
	localparam int OPW   = 33;
	localparam int PRODW = 2 * OPW;
	localparam int LIMB  = 32;

	// sequencer last step indices
	localparam logic [4:0] FIT_LAST  = 5'd23;
	localparam logic [4:0] TEST_LAST = 5'd11;

	typedef enum logic [1:0] {
		KIND_HOLD,
		KIND_FIT,
		KIND_TEST
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FLUSH,
		ST_DIVSET,
		ST_DIV,
		ST_DIVEND,
		ST_FINISH
	} bstate_t;

	typedef struct packed {
		logic pop_ready;
		logic start;
		logic hold_out;
		logic mul_issue;
		logic div_load;
		logic degen_set;
		logic div_run;
		logic div_end;
		logic fin_out;
	} bctl_t;

	typedef struct packed {
		logic               is_inlier;
		logic               plane_updated;
		logic               degenerate;
		logic signed [31:0] plane_a;
		logic signed [31:0] plane_b;
		logic signed [31:0] plane_c;
	} result_t;

endpackage

### hdl/pfit_if.sv
// ----------------------------------------------------------------------------
// pfit_if
// Valid/ready channels for input points and result items.
// ----------------------------------------------------------------------------
interface pfit_pt_if #(parameter int COORD_BITS = 16) ();
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;

	modport source (output valid, action, point_x, point_y, point_z, input ready);
	modport sink   (input valid, action, point_x, point_y, point_z, output ready);
endinterface

interface pfit_res_if ();
	logic               valid;
	logic               ready;
	logic               is_inlier;
	logic               plane_updated;
	logic               degenerate;
	logic signed [31:0] plane_a;
	logic signed [31:0] plane_b;
	logic signed [31:0] plane_c;

	modport source (output valid, is_inlier, plane_updated, degenerate, plane_a, plane_b,
		plane_c, input ready);
	modport sink   (input valid, is_inlier, plane_updated, degenerate, plane_a, plane_b,
		plane_c, output ready);
endinterface

### hdl/plane_fit_and_inlier_test.sv
// ----------------------------------------------------------------------------
// plane_fit_and_inlier_test
// Three-point plane fit (A*x+B*y+C*z=1) and point-to-plane inlier test.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle, while the queue has room, into a
// two-entry queue; the back end works through one item at a time with a
// single 33x33 multiplier and a one-bit-per-cycle divider. A partial fit
// item (first or second sample) is answered straight from the idle state,
// a test item runs 12 multiplier steps plus load, flush and result, and a
// completing fit also divides once per coefficient, with NDW the dividend
// width (64 bits at 16-bit coordinates); a fit with zero determinant
// skips the division. Results leave through a registered output stage, so
// the queue keeps filling while a result waits to be taken.
// ----------------------------------------------------------------------------
module plane_fit_and_inlier_test
	import pfit_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [THRESH_W-1:0] cfg_wr_data,
	pfit_pt_if.sink             points,
	pfit_res_if.source          results
);
	localparam int EW = $bits(kind_t) + 9 * COORD_BITS;

	logic [THRESH_W-1:0] thr_q;
	logic                push_valid, push_ready;
	logic [EW-1:0]       push_entry;
	logic                pop_valid, pop_ready;
	logic [EW-1:0]       pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THRESH_RESET;
		else if (cfg_wr_en)
			thr_q <= cfg_wr_data;
	end

	pfit_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.points     (points),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	pfit_queue #(.WIDTH(EW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_entry)
	);

	pfit_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.threshold  (thr_q),
		.results    (results)
	);

`ifndef SYNTH
	// a fit item never reports an inlier
	a_fit_not_inlier: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !(results.is_inlier && results.plane_updated))
		else $error("fit item flagged as inlier");

	// no inlier without a valid plane
	a_inlier_needs_plane: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.is_inlier |-> !results.degenerate)
		else $error("inlier reported on degenerate plane");

	// a degenerate plane always carries zero coefficients
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.degenerate |->
			results.plane_a == 0 && results.plane_b == 0 && results.plane_c == 0)
		else $error("degenerate plane with nonzero coefficients");

	// the queue cannot produce an item it was never given
	a_queue_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!pop_valid && !(push_valid && push_ready) |=> !pop_valid)
		else $error("queue presented an item without a push");
`endif

endmodule

### hdl/pfit_queue.sv
// ----------------------------------------------------------------------------
// pfit_queue
// Two-entry FIFO between the classifying front end and the compute back end.
// ----------------------------------------------------------------------------
module pfit_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam logic [1:0] DEPTH = 2'd2;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != DEPTH);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

### hdl/pfit_front.sv
// ----------------------------------------------------------------------------
// pfit_front
// Accepts points, collects fit samples and classifies each item for the
// back end: hold (partial fit), fit (third sample) or test.
// ----------------------------------------------------------------------------
module pfit_front
	import pfit_pkg::*;
#(
	parameter int COORD_BITS = 16,
	localparam int PW = 3 * COORD_BITS,
	localparam int EW = $bits(kind_t) + 3 * PW
) (
	input  logic          clk,
	input  logic          arst_n,
	pfit_pt_if.sink       points,
	output logic          push_valid,
	input  logic          push_ready,
	output logic [EW-1:0] push_entry
);
	localparam logic [1:0] COUNT_LAST = 2'd2;

	logic [1:0]    fit_count_q;
	logic [PW-1:0] pts_q [2];
	logic [PW-1:0] cur;
	logic          accept;
	kind_t         kind;

	assign cur          = {points.point_x, points.point_y, points.point_z};
	assign push_valid   = points.valid;
	assign points.ready = push_ready;
	assign accept       = points.valid && push_ready;

	always_comb begin
		if (points.action == ACT_TEST)
			kind = KIND_TEST;
		else if (fit_count_q == COUNT_LAST)
			kind = KIND_FIT;
		else
			kind = KIND_HOLD;
	end

	// slot 2 = first sample, slot 1 = second, slot 0 = this item's point
	assign push_entry = {kind, pts_q[0], pts_q[1], cur};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_count_q <= 2'd0;
		end else if (accept && points.action == ACT_FIT) begin
			fit_count_q <= (fit_count_q == COUNT_LAST) ? 2'd0 : fit_count_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && points.action == ACT_FIT && fit_count_q != COUNT_LAST)
			pts_q[fit_count_q[0]] <= cur;
	end

endmodule

### hdl/pfit_back.sv
// ----------------------------------------------------------------------------
// pfit_back
// Sequenced compute engine: one shared 33x33 multiplier with accumulators
// for the fit minors/determinant and the inlier test, plus a bit-serial
// restoring divider for the coefficients.
// ----------------------------------------------------------------------------
module pfit_back
	import pfit_pkg::*;
#(
	parameter int COORD_BITS = 16,
	localparam int PW = 3 * COORD_BITS,
	localparam int EW = $bits(kind_t) + 3 * PW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  logic [EW-1:0]       pop_entry,
	input  logic [THRESH_W-1:0] threshold,
	pfit_res_if.source          results
);
	localparam int CW   = COORD_BITS;
	localparam int MW   = 2 * CW + 1;
	localparam int NW   = 2 * CW + 3;
	localparam int DW   = 3 * CW + 3;
	localparam int RW   = CW + COEF_W + 2;
	localparam int TTW  = 2 * THRESH_W;
	localparam int N2W  = 2 * LIMB;
	localparam int LHW  = 4 * LIMB;
	localparam int RHW  = TTW + N2W;
	localparam int NSH  = NW + NUM_SHIFT - 1;
	localparam int NDW  = ((NSH > DW - 1) ? NSH : DW - 1) + 1;
	localparam int DCW  = $clog2(NDW);
	localparam logic [DCW-1:0] DCNT_LAST = DCW'(NDW - 1);

	bstate_t state_q, state_d;
	bctl_t   ctl;

	kind_t   pop_kind;
	logic    out_free;
	logic    out_valid_q;
	result_t res_q;

	logic [EW-1:0] ent_q;
	logic          fit_q;
	logic [4:0]    step_q;
	logic [4:0]    step_s1;
	logic          acc_en_s1;
	logic [4:0]    last_step;

	logic signed [CW-1:0] cx [3];
	logic signed [CW-1:0] cy [3];
	logic signed [CW-1:0] cz [3];

	logic signed [OPW-1:0]   op_a, op_b;
	logic signed [PRODW-1:0] mul_full;
	logic signed [PRODW-1:0] prod_s1;
	logic signed [PRODW-1:0] prod_pn;

	logic signed [COEF_W-1:0] coef_q [3];
	logic                     deg_q;

	logic signed [MW-1:0]  m_q [3];
	logic signed [64:0]    m65 [3];
	logic signed [NW-1:0]  na_q, nb_q, nc_q;
	logic signed [DW-1:0]  det_q;
	logic signed [RW-1:0]  r_q;
	logic [RW-1:0]         rmag;
	logic [63:0]           rmag64;
	logic [TTW-1:0]        tt_q;
	logic [N2W-1:0]        n2_q;
	logic [LHW-1:0]        lhs_q;
	logic [RHW-1:0]        rhs_q;

	logic [1:0]           k_q;
	logic                 neg_q;
	logic [NDW-1:0]       n_q;
	logic [DW-1:0]        d_q;
	logic [DW-1:0]        rem_q;
	logic [LIMB-1:0]      quo_q;
	logic                 big_q;
	logic [DCW-1:0]       dcnt_q;
	logic signed [NW-1:0] num_sel;
	logic [NW-1:0]        nabs;
	logic [DW-1:0]        dabs;
	logic [DW:0]          trial;
	logic                 ge;
	logic signed [COEF_W-1:0] sat_coef;
	logic                 det_zero;

	assign pop_kind = kind_t'(pop_entry[EW-1 -: $bits(kind_t)]);
	assign out_free = !out_valid_q || results.ready;
	assign last_step = fit_q ? FIT_LAST : TEST_LAST;
	assign det_zero = (det_q == '0);

	// point i (0 = first sample) sits in slot 2-i
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cx[i] = ent_q[(2 - i) * PW + 2 * CW +: CW];
			cy[i] = ent_q[(2 - i) * PW + CW +: CW];
			cz[i] = ent_q[(2 - i) * PW +: CW];
			m65[i] = 65'(m_q[i]);
		end
	end

	assign rmag   = r_q[RW-1] ? RW'(-r_q) : RW'(r_q);
	assign rmag64 = 64'(rmag);

	// ---------------- state machine ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid && out_free && pop_kind != KIND_HOLD)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				if (step_q == last_step)
					state_d = ST_FLUSH;
			end
			ST_FLUSH:  state_d = fit_q ? ST_DIVSET : ST_FINISH;
			ST_DIVSET: state_d = det_zero ? ST_FINISH : ST_DIV;
			ST_DIV: begin
				if (dcnt_q == DCNT_LAST)
					state_d = ST_DIVEND;
			end
			ST_DIVEND: state_d = (k_q == 2'd2) ? ST_FINISH : ST_DIVSET;
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.pop_ready = out_free;
				ctl.start     = out_free && pop_valid && pop_kind != KIND_HOLD;
				ctl.hold_out  = out_free && pop_valid && pop_kind == KIND_HOLD;
			end
			ST_MUL:    ctl.mul_issue = 1'b1;
			ST_DIVSET: begin
				ctl.div_load  = !det_zero;
				ctl.degen_set = det_zero;
			end
			ST_DIV:    ctl.div_run = 1'b1;
			ST_DIVEND: ctl.div_end = 1'b1;
			ST_FINISH: ctl.fin_out = out_free;
			default:   ctl = '0;
		endcase
	end

	assign pop_ready = ctl.pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------- multiplier operand select ----------------
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (fit_q) begin
			case (step_q)
				5'd0:  begin op_a = OPW'(cy[1]); op_b = OPW'(cz[2]); end
				5'd1:  begin op_a = OPW'(cy[2]); op_b = OPW'(cz[1]); end
				5'd2:  begin op_a = OPW'(cy[2]); op_b = OPW'(cz[0]); end
				5'd3:  begin op_a = OPW'(cy[0]); op_b = OPW'(cz[2]); end
				5'd4:  begin op_a = OPW'(cy[0]); op_b = OPW'(cz[1]); end
				5'd5:  begin op_a = OPW'(cy[1]); op_b = OPW'(cz[0]); end
				5'd6:  begin op_a = OPW'(cx[2]); op_b = OPW'(cz[1]); end
				5'd7:  begin op_a = OPW'(cx[1]); op_b = OPW'(cz[2]); end
				5'd8:  begin op_a = OPW'(cx[0]); op_b = OPW'(cz[2]); end
				5'd9:  begin op_a = OPW'(cx[2]); op_b = OPW'(cz[0]); end
				5'd10: begin op_a = OPW'(cx[1]); op_b = OPW'(cz[0]); end
				5'd11: begin op_a = OPW'(cx[0]); op_b = OPW'(cz[1]); end
				5'd12: begin op_a = OPW'(cx[1]); op_b = OPW'(cy[2]); end
				5'd13: begin op_a = OPW'(cx[2]); op_b = OPW'(cy[1]); end
				5'd14: begin op_a = OPW'(cx[2]); op_b = OPW'(cy[0]); end
				5'd15: begin op_a = OPW'(cx[0]); op_b = OPW'(cy[2]); end
				5'd16: begin op_a = OPW'(cx[0]); op_b = OPW'(cy[1]); end
				5'd17: begin op_a = OPW'(cx[1]); op_b = OPW'(cy[0]); end
				// determinant: x_i times minor_i, minor split in low/high limbs
				5'd18: begin op_a = OPW'(cx[0]); op_b = {1'b0, m65[0][LIMB-1:0]}; end
				5'd19: begin op_a = OPW'(cx[0]); op_b = m65[0][64:LIMB]; end
				5'd20: begin op_a = OPW'(cx[1]); op_b = {1'b0, m65[1][LIMB-1:0]}; end
				5'd21: begin op_a = OPW'(cx[1]); op_b = m65[1][64:LIMB]; end
				5'd22: begin op_a = OPW'(cx[2]); op_b = {1'b0, m65[2][LIMB-1:0]}; end
				5'd23: begin op_a = OPW'(cx[2]); op_b = m65[2][64:LIMB]; end
				default: begin op_a = '0; op_b = '0; end
			endcase
		end else begin
			case (step_q)
				5'd0:  begin op_a = OPW'(coef_q[0]); op_b = OPW'(cx[2]); end
				5'd1:  begin op_a = OPW'(coef_q[1]); op_b = OPW'(cy[2]); end
				5'd2:  begin op_a = OPW'(coef_q[2]); op_b = OPW'(cz[2]); end
				5'd3:  begin op_a = OPW'(threshold); op_b = OPW'(threshold); end
				5'd4:  begin op_a = OPW'(coef_q[0]); op_b = OPW'(coef_q[0]); end
				5'd5:  begin op_a = OPW'(coef_q[1]); op_b = OPW'(coef_q[1]); end
				5'd6:  begin op_a = OPW'(coef_q[2]); op_b = OPW'(coef_q[2]); end
				5'd7:  begin op_a = {1'b0, rmag64[31:0]};  op_b = {1'b0, rmag64[31:0]}; end
				5'd8:  begin op_a = {1'b0, rmag64[63:32]}; op_b = {1'b0, rmag64[31:0]}; end
				5'd9:  begin op_a = {1'b0, rmag64[63:32]}; op_b = {1'b0, rmag64[63:32]}; end
				5'd10: begin op_a = OPW'(tt_q); op_b = {1'b0, n2_q[31:0]}; end
				5'd11: begin op_a = OPW'(tt_q); op_b = {1'b0, n2_q[63:32]}; end
				default: begin op_a = '0; op_b = '0; end
			endcase
		end
	end

	assign mul_full = op_a * op_b;
	assign prod_pn  = step_s1[0] ? -prod_s1 : prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_en_s1 <= 1'b0;
		else
			acc_en_s1 <= ctl.mul_issue;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_full;
		step_s1 <= step_q;
		if (ctl.start)
			step_q <= 5'd0;
		else if (ctl.mul_issue)
			step_q <= step_q + 5'd1;
		if (ctl.start) begin
			ent_q <= pop_entry;
			fit_q <= (pop_kind == KIND_FIT);
		end
	end

	// ---------------- accumulators ----------------
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 3; i++)
				m_q[i] <= '0;
			na_q  <= '0;
			nb_q  <= '0;
			nc_q  <= '0;
			det_q <= '0;
			r_q   <= RW'(-COEF_ONE);
			n2_q  <= '0;
			lhs_q <= '0;
			rhs_q <= '0;
		end else if (acc_en_s1) begin
			if (fit_q) begin
				if (step_s1 < 5'd6) begin
					m_q[step_s1[2:1]] <= m_q[step_s1[2:1]] + MW'(prod_pn);
					na_q <= na_q + NW'(prod_pn);
				end else if (step_s1 < 5'd12) begin
					nb_q <= nb_q + NW'(prod_pn);
				end else if (step_s1 < 5'd18) begin
					nc_q <= nc_q + NW'(prod_pn);
				end else if (step_s1[0]) begin
					det_q <= det_q + (DW'(prod_s1) <<< LIMB);
				end else begin
					det_q <= det_q + DW'(prod_s1);
				end
			end else begin
				case (step_s1)
					5'd0, 5'd1, 5'd2: r_q <= r_q + RW'(prod_s1);
					5'd3:             tt_q <= TTW'(prod_s1);
					5'd4, 5'd5, 5'd6: n2_q <= n2_q + N2W'(prod_s1);
					5'd7:             lhs_q <= lhs_q + LHW'(prod_s1);
					5'd8:             lhs_q <= lhs_q + (LHW'(prod_s1) << (LIMB + 1));
					5'd9:             lhs_q <= lhs_q + (LHW'(prod_s1) << (2 * LIMB));
					5'd10:            rhs_q <= rhs_q + RHW'(prod_s1);
					5'd11:            rhs_q <= rhs_q + (RHW'(prod_s1) << LIMB);
					default:          r_q <= r_q;
				endcase
			end
		end
	end

	// ---------------- divider ----------------
	always_comb begin
		case (k_q)
			2'd0:    num_sel = na_q;
			2'd1:    num_sel = nb_q;
			default: num_sel = nc_q;
		endcase
	end

	assign nabs  = num_sel[NW-1] ? NW'(-num_sel) : NW'(num_sel);
	assign dabs  = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
	assign trial = {rem_q, n_q[NDW-1]};
	assign ge    = (trial >= {1'b0, d_q});

	// round half away from zero, then saturate to 32 bits
	always_comb begin
		if (neg_q) begin
			if (big_q || quo_q > 32'h8000_0000)
				sat_coef = 32'sh8000_0000;
			else
				sat_coef = -$signed(quo_q);
		end else begin
			if (big_q || quo_q[LIMB-1])
				sat_coef = 32'sh7FFF_FFFF;
			else
				sat_coef = $signed(quo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			neg_q <= num_sel[NW-1] ^ det_q[DW-1];
			n_q   <= (NDW'(nabs) << NUM_SHIFT) + NDW'(dabs);
			d_q   <= dabs << 1;
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (ctl.div_run) begin
			rem_q <= ge ? DW'(trial - {1'b0, d_q}) : DW'(trial);
			n_q   <= n_q << 1;
			quo_q <= {quo_q[LIMB-2:0], ge};
			big_q <= big_q | quo_q[LIMB-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= 2'd0;
			dcnt_q <= '0;
		end else begin
			if (ctl.start)
				k_q <= 2'd0;
			else if (ctl.div_end)
				k_q <= k_q + 2'd1;
			if (ctl.div_load)
				dcnt_q <= '0;
			else if (ctl.div_run)
				dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	// ---------------- plane state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				coef_q[i] <= '0;
			deg_q <= 1'b1;
		end else begin
			if (ctl.degen_set) begin
				for (int i = 0; i < 3; i++)
					coef_q[i] <= '0;
				deg_q <= 1'b1;
			end else if (ctl.div_end) begin
				coef_q[k_q] <= sat_coef;
				if (k_q == 2'd2)
					deg_q <= 1'b0;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.hold_out || ctl.fin_out)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.hold_out || ctl.fin_out) begin
			res_q.is_inlier     <= ctl.fin_out && !fit_q && !deg_q &&
				(lhs_q < LHW'(rhs_q));
			res_q.plane_updated <= ctl.fin_out && fit_q;
			res_q.degenerate    <= deg_q;
			res_q.plane_a       <= coef_q[0];
			res_q.plane_b       <= coef_q[1];
			res_q.plane_c       <= coef_q[2];
		end
	end

	assign results.valid         = out_valid_q;
	assign results.is_inlier     = res_q.is_inlier;
	assign results.plane_updated = res_q.plane_updated;
	assign results.degenerate    = res_q.degenerate;
	assign results.plane_a       = res_q.plane_a;
	assign results.plane_b       = res_q.plane_b;
	assign results.plane_c       = res_q.plane_c;

endmodule

### verif/pfit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfit_checker
// Watches the point and result channels, predicts each result from its own
// copy of the plane state and threshold, and compares field by field.
// ----------------------------------------------------------------------------
module pfit_checker
	import pfit_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [THRESH_W-1:0] cfg_wr_data,
	pfit_pt_if                  points,
	pfit_res_if                 results,
	output int                  fail_count,
	output int                  pending,
	output int                  fits_done,
	output int                  inliers_seen
);

	typedef logic signed [255:0] wide_t;

	logic signed [15:0]       samp_x[3], samp_y[3], samp_z[3];
	int                       samp_idx;
	logic signed [COEF_W-1:0] coef[3];
	bit                       degen;
	logic [THRESH_W-1:0]      thresh;
	result_t                  expected_results[$];

	// round to nearest (ties away from zero), then saturate to 32 bits
	function automatic logic signed [31:0] coef_round(wide_t num, wide_t den);
		wide_t n, d, q;
		bit neg;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = ((n <<< NUM_SHIFT) + d) / (d + d);
		if (neg) begin
			if (q > 256'sh80000000)
				return 32'sh80000000;
			return -q[31:0];
		end
		if (q > 256'sh7fffffff)
			return 32'sh7fffffff;
		return q[31:0];
	endfunction

	function automatic wide_t minor2(wide_t a, wide_t b, wide_t c, wide_t d);
		return a * b - c * d;
	endfunction

	task automatic fit_plane();
		wide_t x1, y1, z1, x2, y2, z2, x3, y3, z3, m0, m1, m2, det, na, nb, nc;
		x1 = samp_x[0]; y1 = samp_y[0]; z1 = samp_z[0];
		x2 = samp_x[1]; y2 = samp_y[1]; z2 = samp_z[1];
		x3 = samp_x[2]; y3 = samp_y[2]; z3 = samp_z[2];
		m0 = minor2(y2, z3, y3, z2);
		m1 = minor2(y3, z1, y1, z3);
		m2 = minor2(y1, z2, y2, z1);
		det = x1 * m0 + x2 * m1 + x3 * m2;
		na = m0 + m1 + m2;
		nb = minor2(x3, z2, x2, z3) + minor2(x1, z3, x3, z1) + minor2(x2, z1, x1, z2);
		nc = minor2(x2, y3, x3, y2) + minor2(x3, y1, x1, y3) + minor2(x1, y2, x2, y1);
		if (det == 0) begin
			coef[0] = '0; coef[1] = '0; coef[2] = '0;
			degen = 1'b1;
		end else begin
			coef[0] = coef_round(na, det);
			coef[1] = coef_round(nb, det);
			coef[2] = coef_round(nc, det);
			degen = 1'b0;
		end
	endtask

	// compare squared distance against squared threshold times |n|^2
	function automatic bit within_threshold(wide_t x, wide_t y, wide_t z);
		wide_t a, b, c, r, n2, t;
		if (degen)
			return 1'b0;
		a = coef[0]; b = coef[1]; c = coef[2];
		r = a * x + b * y + c * z - wide_t'(COEF_ONE);
		if (r < 0)
			r = -r;
		n2 = a * a + b * b + c * c;
		t = {241'b0, thresh};
		return (r * r) < (t * t * n2);
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			samp_idx = 0;
			coef[0] = '0; coef[1] = '0; coef[2] = '0;
			degen = 1'b1;
			thresh = THRESH_RESET;
			expected_results.delete();
			fail_count = 0;
			fits_done = 0;
			inliers_seen = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no expectation waiting");
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("is_inlier", exp_r.is_inlier, results.is_inlier);
					check_field("plane_updated", exp_r.plane_updated, results.plane_updated);
					check_field("degenerate", exp_r.degenerate, results.degenerate);
					check_field("plane_a", exp_r.plane_a, results.plane_a);
					check_field("plane_b", exp_r.plane_b, results.plane_b);
					check_field("plane_c", exp_r.plane_c, results.plane_c);
				end
			end
			if (points.valid && points.ready) begin
				exp_r = '0;
				if (points.action == ACT_FIT) begin
					samp_x[samp_idx] = points.point_x;
					samp_y[samp_idx] = points.point_y;
					samp_z[samp_idx] = points.point_z;
					samp_idx++;
					if (samp_idx == 3) begin
						samp_idx = 0;
						fit_plane();
						exp_r.plane_updated = 1'b1;
						fits_done++;
					end
				end else begin
					exp_r.is_inlier = within_threshold(points.point_x, points.point_y,
						points.point_z);
					if (exp_r.is_inlier)
						inliers_seen++;
				end
				exp_r.degenerate = degen;
				exp_r.plane_a = coef[0];
				exp_r.plane_b = coef[1];
				exp_r.plane_c = coef[2];
				expected_results.push_back(exp_r);
			end
			if (cfg_wr_en)
				thresh = cfg_wr_data;
		end
		pending = expected_results.size();
	end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives fit triplets and test points into the plane fit block with bursty
// input and a stalling receiver, over several thresholds; the checker
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
	import pfit_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [THRESH_W-1:0] cfg_wr_data;
	int                  fail_count, pending, fits_done, inliers_seen;
	int                  burst_left;
	int                  stall_pct;
	int                  stall_cnt;
	int                  sent;
	logic signed [15:0]  last_x[3], last_y[3], last_z[3];

	pfit_pt_if #(.COORD_BITS(16)) pt_ch ();
	pfit_res_if                   res_ch ();

	plane_fit_and_inlier_test #(.COORD_BITS(16)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.points     (pt_ch),
		.results    (res_ch)
	);

	pfit_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.points      (pt_ch),
		.results     (res_ch),
		.fail_count  (fail_count),
		.pending     (pending),
		.fits_done   (fits_done),
		.inliers_seen(inliers_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver stall pattern: the stall rate is redrawn whenever stall_cnt runs out
	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			stall_cnt = 64;
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 30;
				2: stall_pct = 70;
				default: stall_pct = 95;
			endcase
		end
		stall_cnt--;
		res_ch.ready = ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_point(logic act, logic signed [15:0] x, y, z);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pt_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pt_ch.valid = 1'b1;
		pt_ch.action = act;
		pt_ch.point_x = x;
		pt_ch.point_y = y;
		pt_ch.point_z = z;
		if (act == ACT_FIT) begin
			last_x[sent % 3] = x;
			last_y[sent % 3] = y;
			last_z[sent % 3] = z;
			sent++;
		end
		@(posedge clk);
		while (!pt_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		pt_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_thresh(logic [THRESH_W-1:0] v);
		drain();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function automatic logic signed [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'($urandom_range(0, 4000) - 2000);
			1: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 16) - 8);
		endcase
	endfunction

	task automatic random_phase(int n_items);
		int i, k, pick, mode;
		logic signed [15:0] x, y, z;
		i = 0;
		while (i < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				mode = $urandom_range(0, 9);
				mode = (mode < 7) ? 0 : (mode < 9) ? 1 : 2;
				if ($urandom_range(0, 9) == 0) begin
					// repeated point: zero determinant
					x = rand_coord(mode); y = rand_coord(mode); z = rand_coord(mode);
					repeat (3) send_point(ACT_FIT, x, y, z);
				end else begin
					repeat (3) send_point(ACT_FIT, rand_coord(mode), rand_coord(mode),
						rand_coord(mode));
				end
				i += 3;
			end else if (pick < 30) begin
				send_point(ACT_FIT, rand_coord(1), rand_coord(1), rand_coord(1));
				i++;
			end else if (pick < 80) begin
				// near a recent fit point, so inliers do occur
				k = $urandom_range(0, 2);
				send_point(ACT_TEST,
					16'(last_x[k] + rand_coord(2) * $urandom_range(0, 12)),
					16'(last_y[k] + rand_coord(2) * $urandom_range(0, 12)),
					16'(last_z[k] + rand_coord(2) * $urandom_range(0, 12)));
				i++;
			end else begin
				send_point(ACT_TEST, rand_coord(1), rand_coord(1), rand_coord(1));
				i++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		pt_ch.valid = 1'b0;
		pt_ch.action = ACT_FIT;
		pt_ch.point_x = '0;
		pt_ch.point_y = '0;
		pt_ch.point_z = '0;
		res_ch.ready = 1'b0;
		stall_cnt = 0;
		stall_pct = 0;
		burst_left = 0;
		sent = 0;
		for (int j = 0; j < 3; j++) begin
			last_x[j] = '0; last_y[j] = '0; last_z[j] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no plane yet
		send_point(ACT_TEST, 16'sd4096, 16'sd0, 16'sd0);
		send_point(ACT_TEST, 16'sh7fff, -16'sh8000, 16'sh7fff);
		// plane x+y+z=1
		send_point(ACT_FIT, 16'sd4096, 16'sd0, 16'sd0);
		send_point(ACT_FIT, 16'sd0, 16'sd4096, 16'sd0);
		send_point(ACT_FIT, 16'sd0, 16'sd0, 16'sd4096);
		send_point(ACT_TEST, 16'sd4096, 16'sd0, 16'sd0);
		send_point(ACT_TEST, 16'sd1365, 16'sd1365, 16'sd1366);
		send_point(ACT_TEST, 16'sd0, 16'sd0, 16'sd0);
		send_point(ACT_TEST, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_point(ACT_TEST, -16'sh8000, -16'sh8000, -16'sh8000);
		// plane almost through the origin: coefficients saturate
		send_point(ACT_FIT, 16'sd1, 16'sd1, 16'sd0);
		send_point(ACT_FIT, 16'sd1, 16'sd1, 16'sd5);
		send_point(ACT_FIT, -16'sd32765, -16'sd32766, 16'sd0);
		send_point(ACT_TEST, 16'sd1, 16'sd1, 16'sd100);
		send_point(ACT_TEST, 16'sd2, 16'sd1, 16'sd0);
		// zero determinant
		send_point(ACT_FIT, 16'sd0, 16'sd0, 16'sd0);
		send_point(ACT_FIT, 16'sd0, 16'sd0, 16'sd0);
		send_point(ACT_FIT, 16'sd0, 16'sd0, 16'sd0);
		send_point(ACT_TEST, 16'sd0, 16'sd0, 16'sd0);
		send_point(ACT_FIT, -16'sh8000, 16'sh7fff, -16'sh8000);
		send_point(ACT_FIT, 16'sh7fff, -16'sh8000, 16'sh7fff);
		send_point(ACT_FIT, 16'sd3000, 16'sd100, -16'sd2000);
		send_point(ACT_TEST, 16'sd3000, 16'sd100, -16'sd2000);

		random_phase(100);
		write_thresh('0);
		random_phase(90);
		write_thresh(15'h7fff);
		random_phase(90);
		write_thresh(15'd1);
		random_phase(90);
		write_thresh(THRESH_W'($urandom_range(0, 32767)));
		random_phase(90);
		write_thresh(15'd82);
		random_phase(90);
		write_thresh(THRESH_W'($urandom_range(50, 600)));
		random_phase(90);

		drain();
		$display("Covered %0d completed fits and %0d inlier hits over 7 threshold settings.",
			fits_done, inliers_seen);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10ms;
		$display("Timeout: %0d results still outstanding", pending);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### plane_fit_and_inlier_test.f
hdl/pfit_pkg.sv
hdl/pfit_if.sv
hdl/pfit_queue.sv
hdl/pfit_front.sv
hdl/pfit_back.sv
hdl/plane_fit_and_inlier_test.sv
verif/pfit_checker.sv
verif/tb.sv
